FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SFR_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SFR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int SFR_WINDOW_LEN  = 24;
  localparam int SFR_NUM_ANALOG  = 16;
  localparam int SFR_CH_W        = 11;
  localparam int SFR_PAYLOAD_W   = SFR_NUM_ANALOG * SFR_CH_W;
  localparam int SFR_QUEUE_DEPTH = 2;
  localparam int SFR_ADDR_W      = 3;

  localparam logic [7:0] SFR_SYNC_BYTE   = 8'h0F;
  localparam logic [7:0] SFR_END_BYTE    = 8'h00;
  localparam logic [7:0] SFR_LIMIT_RESET = 8'd50;
  localparam logic [7:0] SFR_COUNT_MAX   = 8'hFF;

  localparam logic [4:0] SFR_FLAG_HI_INDEX = 5'd16;
  localparam logic [4:0] SFR_FLAG_LO_INDEX = 5'd17;

  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  localparam logic REG_SEARCH_LIMIT = 1'b0;

  typedef struct packed {
    logic                     is_timeout;
    logic [SFR_PAYLOAD_W-1:0] payload;
    logic [1:0]               flags;
  } sfr_record_t;

  typedef struct packed {
    logic valid;
    logic full;
  } sfr_push_t;

endpackage

FILE: rtl/sfr_front.sv
`timescale 1ns / 1ps

module sfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          search_limit,
  output logic                rec_valid,
  output sfr_pkg::sfr_record_t rec
);
  import sfr_pkg::*;

  logic [7:0] window [0:SFR_WINDOW_LEN-1];
  logic [7:0] bytes_seen;
  logic [7:0] bytes_seen_next;
  logic       frame_hit;
  logic       timeout_hit;

  always_comb begin
    bytes_seen_next = (bytes_seen == SFR_COUNT_MAX) ? bytes_seen : bytes_seen + 8'd1;
    frame_hit       = (window[0] == SFR_SYNC_BYTE) && (rx_byte == SFR_END_BYTE);
    timeout_hit     = !frame_hit && (bytes_seen_next >= search_limit);
    rec_valid       = byte_valid && (frame_hit || timeout_hit);
    rec.is_timeout  = !frame_hit;
    for (int i = 1; i <= SFR_NUM_ANALOG * SFR_CH_W / 8; i++) begin
      rec.payload[(i-1)*8 +: 8] = window[i];
    end
    rec.flags = window[SFR_WINDOW_LEN-1][7:6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      for (int i = 0; i < SFR_WINDOW_LEN; i++) window[i] <= '0;
    end else if (byte_valid) begin
      if (frame_hit || timeout_hit) begin
        bytes_seen <= '0;
        for (int i = 0; i < SFR_WINDOW_LEN; i++) window[i] <= '0;
      end else begin
        bytes_seen <= bytes_seen_next;
        for (int i = 0; i < SFR_WINDOW_LEN - 1; i++) window[i] <= window[i+1];
        window[SFR_WINDOW_LEN-1] <= rx_byte;
      end
    end
  end

endmodule

FILE: rtl/sfr_queue.sv
`timescale 1ns / 1ps

module sfr_queue #(
  parameter int DEPTH = sfr_pkg::SFR_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfr_pkg::sfr_record_t push_rec,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output sfr_pkg::sfr_record_t head
);
  import sfr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfr_record_t        entries [0:DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/sfr_back.sv
`timescale 1ns / 1ps

module sfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_empty,
  input  sfr_pkg::sfr_record_t rec,
  output logic                 rec_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic                 kind,
  output logic [4:0]           channel_index,
  output logic [10:0]          channel_value,
  output logic                 last
);
  import sfr_pkg::*;

  logic        out_valid;
  logic [4:0]  index;
  logic        load;
  logic        kind_next;
  logic [4:0]  index_out_next;
  logic [10:0] value_next;
  logic        last_next;
  logic [10:0] analog_value;

  always_comb begin
    analog_value = '0;
    for (int i = 0; i < SFR_NUM_ANALOG; i++) begin
      if (index[3:0] == 4'(i)) analog_value = rec.payload[i*SFR_CH_W +: SFR_CH_W];
    end
  end

  always_comb begin
    load = !rec_empty && (!out_valid || pop);
    if (rec.is_timeout) begin
      kind_next      = KIND_TIMEOUT;
      index_out_next = '0;
      value_next     = '0;
      last_next      = 1'b1;
    end else begin
      kind_next      = KIND_CHANNEL;
      index_out_next = index;
      last_next      = (index == SFR_FLAG_LO_INDEX);
      if (index == SFR_FLAG_HI_INDEX)      value_next = {10'b0, rec.flags[1]};
      else if (index == SFR_FLAG_LO_INDEX) value_next = {10'b0, rec.flags[0]};
      else                                 value_next = analog_value;
    end
    rec_pop = load && last_next;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      index     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        index     <= last_next ? '0 : index + 5'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= kind_next;
      channel_index <= index_out_next;
      channel_value <= value_next;
      last          <= last_next;
    end
  end

endmodule

FILE: rtl/sbus_frame_receiver_core.sv
`timescale 1ns / 1ps
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+---------------------------------------------
// bytes in  | push, full                    | rx_byte
// results   | pop, empty                    | kind, channel_index, channel_value, last
// config    | psel, penable, pwrite, pready | paddr, pwdata, prdata (search_limit at 0x0)
//
// One byte is taken per cycle while the record queue between front and back has room.
// A frame yields 18 results and a timeout one, delivered at up to one per cycle from
// the output register; a frame holds its queue entry until its last result is loaded.
// Reset clears the window, the byte count and the queue, empties the output register,
// and sets search_limit to 50. A stalled result side fills the queue, then raises full.

module sbus_frame_receiver_core #(
  parameter int QUEUE_DEPTH = sfr_pkg::SFR_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind,
  output logic [4:0]                    channel_index,
  output logic [10:0]                   channel_value,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::SFR_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sfr_pkg::*;
  `include "assert_macros.svh"

  logic        [7:0] search_limit;
  logic              byte_accept;
  logic              rec_valid;
  sfr_record_t       front_rec;
  sfr_record_t       head_rec;
  logic              rec_empty;
  logic              rec_pop;
  logic              q_full;

  assign pready      = 1'b1;
  assign full        = q_full;
  assign byte_accept = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit <= SFR_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEARCH_LIMIT)) begin
      search_limit <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_SEARCH_LIMIT) ? {24'b0, search_limit} : 32'b0;

  sfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_accept),
    .rx_byte      (rx_byte),
    .search_limit (search_limit),
    .rec_valid    (rec_valid),
    .rec          (front_rec)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_valid),
    .push_rec (front_rec),
    .full     (q_full),
    .empty    (rec_empty),
    .pop      (rec_pop),
    .head     (head_rec)
  );

  sfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_empty     (rec_empty),
    .rec           (head_rec),
    .rec_pop       (rec_pop),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last          (last)
  );

  `SFR_ASSERT_NOW(a_timeout_is_last, !empty && (kind == KIND_TIMEOUT),
                  last && (channel_index == 5'd0))
  `SFR_ASSERT_NOW(a_frame_ends_on_flag, !empty && last && (kind == KIND_CHANNEL),
                  channel_index == SFR_FLAG_LO_INDEX)
  `SFR_ASSERT_NOW(a_no_push_when_full, rec_valid, !q_full)
  `SFR_ASSERT_NEXT(a_record_reaches_back, rec_valid, !rec_empty)

endmodule

FILE: dv/sbus_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module sbus_frame_receiver_core_tb;
  import sfr_pkg::*;

  localparam logic [SFR_ADDR_W-1:0] LIMIT_ADDR = SFR_ADDR_W'(4 * REG_SEARCH_LIMIT);
  localparam int FLAG_BYTE = SFR_WINDOW_LEN - 1;

  typedef struct packed {
    logic        kind;
    logic [4:0]  index;
    logic [10:0] value;
    logic        last;
  } chan_result_t;

  class frame_scoreboard;
    logic [7:0]   window [SFR_WINDOW_LEN];
    logic [7:0]   bytes_seen;
    logic [7:0]   search_limit;
    chan_result_t channels_due[$];
    int           errors;
    int           results_checked;
    int           frames_found;
    int           timeouts_seen;
    int           bytes_taken;

    function new();
      errors = 0;
      results_checked = 0;
      frames_found = 0;
      timeouts_seen = 0;
      bytes_taken = 0;
      clear_search();
      search_limit = SFR_LIMIT_RESET;
    endfunction

    function void clear_search();
      foreach (window[i]) window[i] = '0;
      bytes_seen = '0;
    endfunction

    function void set_limit(logic [7:0] v);
      search_limit = v;
    endfunction

    function int pending();
      return channels_due.size();
    endfunction

    function void note_byte(logic [7:0] rx);
      logic [7:0]   frame [SFR_WINDOW_LEN+1];
      chan_result_t r;
      int           pos;
      for (int i = 0; i < SFR_WINDOW_LEN; i++) frame[i] = window[i];
      frame[SFR_WINDOW_LEN] = rx;
      for (int i = 0; i < SFR_WINDOW_LEN - 1; i++) window[i] = window[i+1];
      window[SFR_WINDOW_LEN-1] = rx;
      bytes_taken++;
      if (bytes_seen != SFR_COUNT_MAX) bytes_seen++;
      if (frame[0] == SFR_SYNC_BYTE && rx == SFR_END_BYTE) begin
        for (int ch = 0; ch < SFR_NUM_ANALOG; ch++) begin
          r.kind = KIND_CHANNEL;
          r.index = 5'(ch);
          r.last = 1'b0;
          for (int b = 0; b < SFR_CH_W; b++) begin
            pos = ch * SFR_CH_W + b;
            r.value[b] = frame[1 + pos / 8][pos % 8];
          end
          channels_due.push_back(r);
        end
        r.value = '0;
        r.index = SFR_FLAG_HI_INDEX;
        r.value[0] = frame[FLAG_BYTE][7];
        channels_due.push_back(r);
        r.index = SFR_FLAG_LO_INDEX;
        r.value[0] = frame[FLAG_BYTE][6];
        r.last = 1'b1;
        channels_due.push_back(r);
        frames_found++;
        clear_search();
      end else if (bytes_seen >= search_limit) begin
        r.kind = KIND_TIMEOUT;
        r.index = '0;
        r.value = '0;
        r.last = 1'b1;
        channels_due.push_back(r);
        timeouts_seen++;
        clear_search();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic got_kind, logic [4:0] got_index, logic [10:0] got_value,
                      logic got_last);
      chan_result_t want;
      results_checked++;
      if (channels_due.size() == 0) begin
        report($sformatf("unexpected result kind=%0d index=%0d value=%0d last=%0d",
                         got_kind, got_index, got_value, got_last));
        return;
      end
      want = channels_due.pop_front();
      if (got_kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got_kind, want.kind));
      if (got_index !== want.index)
        report($sformatf("channel_index %0d, expected %0d", got_index, want.index));
      if (got_value !== want.value)
        report($sformatf("channel_value %0d, expected %0d (channel %0d)",
                         got_value, want.value, want.index));
      if (got_last !== want.last)
        report($sformatf("last %0d, expected %0d (channel %0d)",
                         got_last, want.last, want.index));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte;
  logic        empty;
  logic        pop;
  logic        kind;
  logic [4:0]  channel_index;
  logic [10:0] channel_value;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [SFR_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int stall_left = 0;

  sbus_frame_receiver_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(kind, channel_index, channel_value, last);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = rx_stalls_on ? gap_len() : 0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic pause_push(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_paced(input logic [7:0] b);
    send_byte(b);
    pause_push(tx_gaps_on ? gap_len() : 0);
  endtask

  task automatic send_frame(input bit rand_fill, input logic [7:0] fill,
                            input logic [7:0] end_byte);
    send_paced(SFR_SYNC_BYTE);
    for (int i = 0; i < SFR_WINDOW_LEN - 1; i++)
      send_paced(rand_fill ? 8'($urandom_range(0, 255)) : fill);
    send_paced(end_byte);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_paced(8'($urandom_range(0, 255)));
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (30) @(posedge clk);
  endtask

  task automatic read_limit_check();
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {24'd0, sb.search_limit})
      sb.report($sformatf("search_limit read %0d, expected %0d", got, sb.search_limit));
  endtask

  task automatic write_limit(input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_limit(v);
    @(posedge clk);
    read_limit_check();
  endtask

  initial begin
    int start;
    int r;
    logic [7:0] phase_limit [4];
    sb = new();
    rst <= 1'b1;
    push <= 1'b0;
    rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    read_limit_check();

    // Directed: full-scale and zero channels.
    send_frame(1'b0, 8'hFF, SFR_END_BYTE);
    send_frame(1'b0, 8'h00, SFR_END_BYTE);

    // The frame completes on the very byte that reaches the limit.
    settle();
    write_limit(8'd25);
    send_frame(1'b1, 8'h00, SFR_END_BYTE);
    send_paced(8'hFF);
    send_noise(SFR_WINDOW_LEN - 2);
    send_paced(SFR_END_BYTE);

    // Limits below the frame length only ever time out.
    settle();
    write_limit(8'd0);
    send_noise(3);
    settle();
    write_limit(8'd24);
    send_frame(1'b1, 8'h00, SFR_END_BYTE);
    settle();

    phase_limit[0] = SFR_LIMIT_RESET;
    phase_limit[1] = 8'd25;
    phase_limit[2] = 8'($urandom_range(26, 254));
    phase_limit[3] = SFR_COUNT_MAX;
    for (int p = 0; p < 4; p++) begin
      write_limit(phase_limit[p]);
      tx_gaps_on = (p != 1);
      rx_stalls_on = (p != 1);
      start = sb.bytes_taken;
      while (sb.bytes_taken - start < 15) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_noise($urandom_range(0, 3));
          send_frame(1'b1, 8'h00, SFR_END_BYTE);
        end else if (r < 80) begin
          send_frame(1'b1, 8'h00, 8'($urandom_range(1, 255)));
        end else begin
          send_noise($urandom_range(1, 12));
        end
        if (p == 0 && sb.bytes_taken - start >= 25 && sb.bytes_taken - start < 55
            && r < 5)
          drain_results();
      end
      if (p == 2) drain_results();
      settle();
    end

    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    $display("Run took %0d bytes: %0d frames and %0d search timeouts, %0d results checked.",
             sb.bytes_taken, sb.frames_found, sb.timeouts_seen, sb.results_checked);
    $display("Limits covered 0, 24, 25, 50, %0d and 255, with and without idle gaps.",
             phase_limit[2]);
    if (sb.errors == 0) begin
      $display("[sbus_frame_receiver_core] OK");
    end else begin
      $display("[sbus_frame_receiver_core] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[sbus_frame_receiver_core] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/sbus_frame_receiver_core.sv
dv/sbus_frame_receiver_core_tb.sv
